// File: hdl/ksas_pkg.sv
// Shared types, codes and field layout for the kernel surface area sum block.
`default_nettype none

package ksas_pkg;

    localparam int GRID_SIDE_DEF  = 64;
    localparam int MAX_KERNEL_DEF = 1024;

    // Input item layout, lowest bit first
    localparam int IN_DATA_W   = 80;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 64;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int GRID_REG_W  = 6;
    localparam int COUNT_REG_W = 11;

    localparam int F_VX_LO     = 0;
    localparam int F_VY_LO     = 6;
    localparam int F_VZ_LO     = 12;
    localparam int F_INSIDE    = 18;
    localparam int F_SLOT_LO   = 19;
    localparam int F_OX_LO     = 29;
    localparam int F_OY_LO     = 33;
    localparam int F_OZ_LO     = 37;
    localparam int F_WEIGHT_LO = 41;

    localparam int OFF_W       = 4;
    localparam int WEIGHT_W    = 32;
    localparam int SUM_W       = 64;
    // Kernel table word: {weight, oz, oy, ox}
    localparam int KER_ENTRY_W = WEIGHT_W + 3 * OFF_W;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_X_MAX   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_Y_MAX   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_Z_MAX   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_COUNT = 2'd3;

    localparam logic [IN_USER_W-1:0] ACT_LOAD_VOXEL  = 2'd0;
    localparam logic [IN_USER_W-1:0] ACT_LOAD_KERNEL = 2'd1;
    localparam logic [IN_USER_W-1:0] ACT_COMPUTE     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOX,
        ST_CHK,
        ST_NBR,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctl_t;

endpackage

`default_nettype wire

// File: hdl/ksas_accum.sv
// Saturating 64-bit accumulator with sticky overflow flag.
`default_nettype none

module ksas_accum
    import ksas_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire acc_ctl_t                   ctl,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    output logic signed [SUM_W-1:0]         sum,
    output logic                            ovf
);

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic signed [SUM_W-1:0] wext;
    logic signed [SUM_W-1:0] raw;
    logic                    ovf_now;

    always_comb
    begin
        wext    = {{(SUM_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
        raw     = acc_reg + wext;
        ovf_now = (acc_reg[SUM_W-1] == wext[SUM_W-1]) && (raw[SUM_W-1] != acc_reg[SUM_W-1]);
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctl.add)
        begin
            if (ovf_now)
            begin
                // clamp toward the sign of the weight
                acc_next = wext[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
        end
    end

    assign sum = acc_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

// File: hdl/kernel_surface_area_sum.sv
// Top level: voxel flag memory, kernel table, walk sequencer and result register.
//
// Usage:
//   s_* channel takes one item per handshake; s_tuser holds the action code.
//   Load-voxel and load-kernel items give no result.
//   A compute item walks every voxel of the configured box (z fastest), and for
//   each inside voxel every kernel entry, adding the entry weight whenever the
//   neighbor is outside the box or an outside voxel. One result leaves on m_*.
//   The single read port of the voxel flag memory is shared between the center
//   lookup and each neighbor lookup. s_tready is low while a compute runs.
//   The result sits in an output register; new items are taken while it waits.
//   A later compute that finishes while the result register is still full
//   holds until the register frees.
//   Reset clears the sequencer, the accumulator and the config registers
//   (bounds 63, kernel count 0); the flag memory and kernel table are not
//   cleared and must be loaded before use. cfg_* writes land at once.
`default_nettype none

module kernel_surface_area_sum
    import ksas_pkg::*;
#(
    parameter int GRID_SIDE          = GRID_SIDE_DEF,
    parameter int MAX_KERNEL_ENTRIES = MAX_KERNEL_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // voxel_x, voxel_y, voxel_z, inside_req, entry_slot, offset_x, offset_y,
    // offset_z, kernel_weight, zero fill
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // action
    input  wire logic [IN_USER_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // area_sum
    output logic [OUT_DATA_W-1:0]       m_tdata,
    // overflowed
    output logic [OUT_USER_W-1:0]       m_tuser,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW        = $clog2(GRID_SIDE);
    localparam int AW        = 3 * CW;
    localparam int VOX_DEPTH = 1 << AW;
    localparam int KW        = $clog2(MAX_KERNEL_ENTRIES);
    localparam int NW        = $clog2(MAX_KERNEL_ENTRIES + 1);
    localparam int NCW       = ((CW > OFF_W) ? CW : OFF_W) + 2;

    // Config registers
    logic [GRID_REG_W-1:0]  grid_x_max_reg;
    logic [GRID_REG_W-1:0]  grid_y_max_reg;
    logic [GRID_REG_W-1:0]  grid_z_max_reg;
    logic [COUNT_REG_W-1:0] kernel_count_reg;

    // Walk state
    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  x_reg, x_next;
    logic [CW-1:0]  y_reg, y_next;
    logic [CW-1:0]  z_reg, z_next;
    logic [NW-1:0]  e_reg, e_next;
    logic [CW-1:0]  xm_reg, xm_next;
    logic [CW-1:0]  ym_reg, ym_next;
    logic [CW-1:0]  zm_reg, zm_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic           oob_reg, oob_next;

    // Memories
    logic                   flag_mem [0:VOX_DEPTH-1];
    logic [KER_ENTRY_W-1:0] ker_mem  [0:MAX_KERNEL_ENTRIES-1];
    logic                   flag_q;
    logic [KER_ENTRY_W-1:0] ker_q;
    logic [AW-1:0]          flag_addr;
    logic [KW-1:0]          ker_addr;

    // Result register
    logic                   out_valid_reg;
    logic [SUM_W-1:0]       out_sum_reg;
    logic                   out_ovf_reg;
    logic                   out_load;

    // Input decode
    logic                   s_fire;
    logic [IN_USER_W-1:0]   act;
    logic [CW-1:0]          in_x, in_y, in_z;
    logic [KW-1:0]          in_slot;
    logic                   vox_we;
    logic                   ker_we;
    logic [KER_ENTRY_W-1:0] ker_wdata;

    // Walk helpers
    logic                   last_x, last_y, last_z, vox_last;
    logic                   entry_last;
    logic                   center_active;
    logic signed [NCW-1:0]  nx, ny, nz;
    logic                   nbr_oob;
    acc_ctl_t               acc_ctl;
    logic signed [SUM_W-1:0] acc_sum;
    logic                   acc_ovf;

    assign s_fire    = s_tvalid && s_tready;
    assign act       = s_tuser;
    assign in_x      = CW'(s_tdata[F_VX_LO +: GRID_REG_W]);
    assign in_y      = CW'(s_tdata[F_VY_LO +: GRID_REG_W]);
    assign in_z      = CW'(s_tdata[F_VZ_LO +: GRID_REG_W]);
    assign in_slot   = KW'(s_tdata[F_SLOT_LO +: 10]);
    assign ker_wdata = s_tdata[F_OX_LO +: KER_ENTRY_W];

    assign vox_we = s_fire && (act == ACT_LOAD_VOXEL)
                    && (32'(s_tdata[F_VX_LO +: GRID_REG_W]) < GRID_SIDE)
                    && (32'(s_tdata[F_VY_LO +: GRID_REG_W]) < GRID_SIDE)
                    && (32'(s_tdata[F_VZ_LO +: GRID_REG_W]) < GRID_SIDE);
    assign ker_we = s_fire && (act == ACT_LOAD_KERNEL)
                    && (32'(s_tdata[F_SLOT_LO +: 10]) < MAX_KERNEL_ENTRIES);

    // Config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_max_reg   <= GRID_REG_W'(63);
            grid_y_max_reg   <= GRID_REG_W'(63);
            grid_z_max_reg   <= GRID_REG_W'(63);
            kernel_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_X_MAX:   grid_x_max_reg   <= cfg_data[GRID_REG_W-1:0];
                REG_GRID_Y_MAX:   grid_y_max_reg   <= cfg_data[GRID_REG_W-1:0];
                REG_GRID_Z_MAX:   grid_z_max_reg   <= cfg_data[GRID_REG_W-1:0];
                REG_KERNEL_COUNT: kernel_count_reg <= cfg_data[COUNT_REG_W-1:0];
            endcase
        end
    end

    // Memories: write on load items, read registered every cycle
    always_ff @(posedge clk)
    begin
        if (vox_we)
        begin
            flag_mem[{in_x, in_y, in_z}] <= s_tdata[F_INSIDE];
        end
        flag_q <= flag_mem[flag_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ker_we)
        begin
            ker_mem[in_slot] <= ker_wdata;
        end
        ker_q <= ker_mem[ker_addr];
    end

    // Neighbor of the current voxel for the entry in ker_q
    always_comb
    begin
        nx = $signed({{(NCW-CW){1'b0}}, x_reg})
             + $signed({{(NCW-OFF_W){ker_q[OFF_W-1]}}, ker_q[OFF_W-1:0]});
        ny = $signed({{(NCW-CW){1'b0}}, y_reg})
             + $signed({{(NCW-OFF_W){ker_q[2*OFF_W-1]}}, ker_q[OFF_W +: OFF_W]});
        nz = $signed({{(NCW-CW){1'b0}}, z_reg})
             + $signed({{(NCW-OFF_W){ker_q[3*OFF_W-1]}}, ker_q[2*OFF_W +: OFF_W]});
        nbr_oob = nx[NCW-1] || ny[NCW-1] || nz[NCW-1]
                  || (nx > $signed({{(NCW-CW){1'b0}}, xm_reg}))
                  || (ny > $signed({{(NCW-CW){1'b0}}, ym_reg}))
                  || (nz > $signed({{(NCW-CW){1'b0}}, zm_reg}));
    end

    assign last_x        = (x_reg == xm_reg);
    assign last_y        = (y_reg == ym_reg);
    assign last_z        = (z_reg == zm_reg);
    assign vox_last      = last_x && last_y && last_z;
    assign entry_last    = ((e_reg + NW'(1)) == cnt_reg);
    assign center_active = flag_q && (cnt_reg != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (act == ACT_COMPUTE))
                begin
                    state_next = ST_VOX;
                end
            end
            ST_VOX:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (center_active)
                begin
                    state_next = ST_NBR;
                end
                else
                begin
                    state_next = vox_last ? ST_DONE : ST_VOX;
                end
            end
            ST_NBR:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (entry_last)
                begin
                    state_next = vox_last ? ST_DONE : ST_VOX;
                end
                else
                begin
                    state_next = ST_NBR;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and walk counters
    always_comb
    begin
        s_tready  = 1'b0;
        out_load  = 1'b0;
        acc_ctl   = '0;
        flag_addr = {x_reg, y_reg, z_reg};
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        e_next    = e_reg;
        xm_next   = xm_reg;
        ym_next   = ym_reg;
        zm_next   = zm_reg;
        cnt_next  = cnt_reg;
        oob_next  = oob_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_fire && (act == ACT_COMPUTE))
                begin
                    acc_ctl.clear = 1'b1;
                    x_next   = '0;
                    y_next   = '0;
                    z_next   = '0;
                    e_next   = '0;
                    // clamp bounds and count to the storage
                    xm_next  = (32'(grid_x_max_reg) > GRID_SIDE - 1) ? CW'(GRID_SIDE - 1)
                                                                     : CW'(grid_x_max_reg);
                    ym_next  = (32'(grid_y_max_reg) > GRID_SIDE - 1) ? CW'(GRID_SIDE - 1)
                                                                     : CW'(grid_y_max_reg);
                    zm_next  = (32'(grid_z_max_reg) > GRID_SIDE - 1) ? CW'(GRID_SIDE - 1)
                                                                     : CW'(grid_z_max_reg);
                    cnt_next = (32'(kernel_count_reg) > MAX_KERNEL_ENTRIES)
                               ? NW'(MAX_KERNEL_ENTRIES) : NW'(kernel_count_reg);
                end
            end
            ST_CHK:
            begin
                if (!center_active && !vox_last)
                begin
                    z_next = last_z ? '0 : z_reg + CW'(1);
                    y_next = last_z ? (last_y ? '0 : y_reg + CW'(1)) : y_reg;
                    x_next = (last_z && last_y) ? x_reg + CW'(1) : x_reg;
                end
            end
            ST_NBR:
            begin
                flag_addr = {nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]};
                oob_next  = nbr_oob;
            end
            ST_ADD:
            begin
                acc_ctl.add = oob_reg || !flag_q;
                if (entry_last)
                begin
                    e_next = '0;
                    if (!vox_last)
                    begin
                        z_next = last_z ? '0 : z_reg + CW'(1);
                        y_next = last_z ? (last_y ? '0 : y_reg + CW'(1)) : y_reg;
                        x_next = (last_z && last_y) ? x_reg + CW'(1) : x_reg;
                    end
                end
                else
                begin
                    e_next = e_reg + NW'(1);
                end
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                acc_ctl = '0;
            end
        endcase
        ker_addr = e_next[KW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            e_reg     <= '0;
            xm_reg    <= '0;
            ym_reg    <= '0;
            zm_reg    <= '0;
            cnt_reg   <= '0;
            oob_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            e_reg     <= e_next;
            xm_reg    <= xm_next;
            ym_reg    <= ym_next;
            zm_reg    <= zm_next;
            cnt_reg   <= cnt_next;
            oob_reg   <= oob_next;
        end
    end

    ksas_accum u_accum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (acc_ctl),
        .weight (ker_q[KER_ENTRY_W-1 -: WEIGHT_W]),
        .sum    (acc_sum),
        .ovf    (acc_ovf)
    );

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sum_reg <= acc_sum;
            out_ovf_reg <= acc_ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTH
    a_entry_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (e_reg < cnt_reg))
        else $error("kernel entry index past count");

    a_nbr_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NBR) |-> (cnt_reg != '0))
        else $error("neighbor lookup with empty kernel table");

    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (x_reg <= xm_reg && y_reg <= ym_reg && z_reg <= zm_reg))
        else $error("voxel walk left the box");

    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("finished compute did not present a result");
`endif

endmodule

`default_nettype wire
